// ----- sv/h264fua_pkg.sv -----
// ----------------------------------------------------------------------------
// h264fua_pkg
// Types and constants shared by the H.264 FU-A depacketizer modules.
// ----------------------------------------------------------------------------
package h264fua_pkg;

    // NAL and FU header fields
    localparam logic [4:0] TYPE_FU_A  = 5'd28;
    localparam logic [4:0] SINGLE_MAX = 5'd23;
    localparam int         START_BIT  = 7;
    localparam int         END_BIT    = 6;

    // Output queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    // Kind of the packet being parsed
    typedef enum logic [1:0] {
        CLASS_DROP   = 2'd0,
        CLASS_SINGLE = 2'd1,
        CLASS_FUA    = 2'd2
    } pkt_class_t;

    // Position inside the current packet
    typedef enum logic [1:0] {
        POS_IDLE   = 2'd0,
        POS_FU_HDR = 2'd1,
        POS_BODY   = 2'd2
    } byte_pos_t;

    // One result item
    typedef struct packed {
        logic [7:0] nal_byte;
        logic       byte_present;
        logic       unit_end;
        logic       last_of_step;
    } result_t;

    // Results caused by one input byte, in order r0 then r1
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_t;

endpackage

// ----- sv/h264_rtp_fua_depacketizer_core.sv -----
// ----------------------------------------------------------------------------
// h264_rtp_fua_depacketizer_core
// RTP H.264 depacketizer for single NAL unit and FU-A packets.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes one RTP payload byte per transfer. tuser marks
//   the first byte of a payload and tlast its last byte. The m_axis channel
//   delivers reassembled NAL bytes; tlast closes a NAL unit, tuser[0] tells a
//   data byte from a marker-only result and tuser[1] flags the final result
//   caused by one input byte.
//   Each input byte is decoded in the same cycle it is taken and its zero,
//   one or two results are written into a four-entry output queue, so a
//   result appears on m_axis once the results queued before it are taken.
//   With m_axis ready, one byte per cycle is taken while each yields at most
//   one result; the output port drains one result per cycle, which sets the
//   rate when start fragments or single NALs add a marker-only result.
//   s_axis_tready stays high while the queue has room for two results, so a
//   stall on m_axis backs up the input once three results are queued; the
//   queue then holds three or four results.
//   Reset empties the queue and returns the parser to the dropping state
//   with no NAL unit open.
// ----------------------------------------------------------------------------
module h264_rtp_fua_depacketizer_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  logic       s_axis_tuser,   // [0] first_in_packet
    input  logic       s_axis_tlast,   // last_in_packet
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] nal_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_present, [1] last_of_step
    output logic       m_axis_tlast    // unit_end
);
    import h264fua_pkg::*;

    logic    in_fire;
    logic    out_fire;
    step_t   step;

    result_t           q_mem [QDEPTH];
    logic [QAW-1:0]    rd_reg, rd_next;
    logic [QAW-1:0]    wr_reg, wr_next;
    logic [QCW-1:0]    cnt_reg, cnt_next;
    logic [QAW-1:0]    wr_plus1;
    logic [QCW-1:0]    add_n;
    result_t           head;

    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign out_fire = m_axis_tvalid & m_axis_tready;

    // Byte decode and reassembly state
    h264fua_parse u_parse
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .payload_byte    (s_axis_tdata),
        .first_in_packet (s_axis_tuser),
        .last_in_packet  (s_axis_tlast),
        .step            (step)
    );

    // Room for a full step of two results
    assign s_axis_tready = (cnt_reg <= QCW'(QDEPTH - 2));

    // Queue pointer and fill count update
    always_comb
    begin
        wr_plus1 = wr_reg + QAW'(1);
        add_n    = in_fire ? QCW'(step.count) : '0;
        wr_next  = wr_reg + add_n[QAW-1:0];
        rd_next  = out_fire ? rd_reg + QAW'(1) : rd_reg;
        cnt_next = cnt_reg + add_n - QCW'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage: the first result at the write pointer, the second after it
    always_ff @(posedge clk)
    begin
        if (in_fire && step.count != 2'd0)
        begin
            q_mem[wr_reg] <= step.r0;
        end
        if (in_fire && step.count == 2'd2)
        begin
            q_mem[wr_plus1] <= step.r1;
        end
    end

    // Output side
    assign head          = q_mem[rd_reg];
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = head.nal_byte;
    assign m_axis_tuser  = {head.last_of_step, head.byte_present};
    assign m_axis_tlast  = head.unit_end;

endmodule

// ----- sv/h264fua_parse.sv -----
// ----------------------------------------------------------------------------
// h264fua_parse
// Packet classifier and FU-A reassembly state; yields up to two results per
// accepted payload byte.
// ----------------------------------------------------------------------------
module h264fua_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          payload_byte,
    input  logic                first_in_packet,
    input  logic                last_in_packet,
    output h264fua_pkg::step_t  step
);
    import h264fua_pkg::*;

    pkt_class_t class_reg, class_next;
    byte_pos_t  pos_reg, pos_next;
    logic       pending_reg, pending_next;
    logic [2:0] ind_reg, ind_next;
    logic       endf_reg, endf_next;

    logic       mark_v;
    logic       data_v;
    logic [7:0] data_byte;
    logic       data_end;
    logic [4:0] type_bits;
    result_t    data_res;

    assign type_bits = payload_byte[4:0];

    // Classification and per-byte decode
    always_comb
    begin
        class_next   = class_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        ind_next     = ind_reg;
        endf_next    = endf_reg;
        mark_v       = 1'b0;
        data_v       = 1'b0;
        data_byte    = payload_byte;
        data_end     = 1'b0;

        if (first_in_packet)
        begin
            endf_next = 1'b0;
            if (type_bits != 5'd0 && type_bits <= SINGLE_MAX)
            begin
                class_next   = CLASS_SINGLE;
                mark_v       = pending_reg;
                data_v       = 1'b1;
                data_end     = last_in_packet;
                pending_next = !last_in_packet;
                pos_next     = POS_BODY;
            end
            else if (type_bits == TYPE_FU_A)
            begin
                class_next = CLASS_FUA;
                ind_next   = payload_byte[7:5];
                pos_next   = POS_FU_HDR;
            end
            else
            begin
                class_next = CLASS_DROP;
                pos_next   = POS_IDLE;
            end
        end
        else if (class_reg == CLASS_SINGLE)
        begin
            data_v       = 1'b1;
            data_end     = last_in_packet;
            pending_next = !last_in_packet;
        end
        else if (class_reg == CLASS_FUA)
        begin
            if (pos_reg == POS_FU_HDR)
            begin
                if (payload_byte[START_BIT])
                begin
                    // Start fragment: close the open unit, then the rebuilt header.
                    mark_v       = pending_reg;
                    data_v       = 1'b1;
                    data_byte    = {ind_reg, type_bits};
                    pending_next = 1'b1;
                    endf_next    = 1'b0;
                end
                else
                begin
                    endf_next = payload_byte[END_BIT];
                    if (payload_byte[END_BIT] && last_in_packet)
                    begin
                        mark_v       = pending_reg;
                        pending_next = 1'b0;
                    end
                end
                pos_next = POS_BODY;
            end
            else
            begin
                data_v       = 1'b1;
                data_end     = endf_reg & last_in_packet;
                pending_next = !(endf_reg & last_in_packet);
            end
        end

        if (last_in_packet)
        begin
            class_next = CLASS_DROP;
            pos_next   = POS_IDLE;
            endf_next  = 1'b0;
        end
    end

    // Result assembly: a marker-only result always comes first.
    always_comb
    begin
        data_res.nal_byte     = data_byte;
        data_res.byte_present = 1'b1;
        data_res.unit_end     = data_end;
        data_res.last_of_step = 1'b1;

        step.count = {1'b0, mark_v} + {1'b0, data_v};
        step.r1    = data_res;
        if (mark_v)
        begin
            step.r0.nal_byte     = 8'd0;
            step.r0.byte_present = 1'b0;
            step.r0.unit_end     = 1'b1;
            step.r0.last_of_step = !data_v;
        end
        else
        begin
            step.r0 = data_res;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg   <= CLASS_DROP;
            pos_reg     <= POS_IDLE;
            pending_reg <= 1'b0;
            ind_reg     <= 3'd0;
            endf_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            class_reg   <= class_next;
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            ind_reg     <= ind_next;
            endf_reg    <= endf_next;
        end
    end

endmodule

// ----- sv/h264fua_chk.sv -----
// ----------------------------------------------------------------------------
// h264fua_chk
// Port-level checks for the H.264 FU-A depacketizer, bound to the top level.
// ----------------------------------------------------------------------------
module h264fua_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // A marker-only result carries a zero byte and closes a unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && m_axis_tlast)
    else $error("malformed marker result");

    // The input side backs up only while results are queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

    // A marker-only result is always followed by another result of the same byte
    // unless it is the last of its step; a second result is never a marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[1] |=>
            m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])
    else $error("first result of a step not followed by its data result");

endmodule

bind h264_rtp_fua_depacketizer_core h264fua_chk u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
